// File: rtl/core/assert_macros.svh
// Assertion helpers for the date adder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define DAD_ASSERT_ON(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: date adder assertion failed");

// Concurrent assertion on the block clock and reset.
`define DAD_ASSERT(label, prop) `DAD_ASSERT_ON(label, clk_i, rst_ni, prop)

`endif

// File: rtl/core/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Types, constants and calendar helpers shared by the date adder modules.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam logic [13:0] MAX_YEAR     = 14'd9999;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;   // December, counted from zero
  localparam logic [3:0]  DEC_NUMBER   = 4'd12;
  localparam logic [4:0]  DEC_LAST_DAY = 5'd31;
  localparam logic [6:0]  CENTURY_LAST = 7'd99;
  localparam logic [6:0]  CENTURY      = 7'd100;
  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for y below 43690.
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [15:0] days_to_add;
  } in_item_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic        year_overflow;
  } out_item_t;

  // Year position handed from the front to the back; the day count rides beside it.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  year_mod100;
    logic [1:0]  century_mod4;
  } job_hdr_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_OUT
  } back_state_e;

  // Gregorian rule from the year's residues modulo 4, 100 and the century count modulo 4.
  function automatic logic is_leap(logic [1:0] year_lo, logic [6:0] mod100,
                                   logic [1:0] cent_mod4);
    logic res;
    if (mod100 != 7'd0) begin
      res = (year_lo == 2'd0);
    end else begin
      res = (cent_mod4 == 2'd0);
    end
    return res;
  endfunction

  // Days in the months before the given month; zero counts as January,
  // anything above twelve as December.
  function automatic logic [8:0] days_before(logic [3:0] month, logic leap);
    logic [8:0] base;
    case (month)
      4'd0, 4'd1: base = 9'd0;
      4'd2:       base = 9'd31;
      4'd3:       base = 9'd59;
      4'd4:       base = 9'd90;
      4'd5:       base = 9'd120;
      4'd6:       base = 9'd151;
      4'd7:       base = 9'd181;
      4'd8:       base = 9'd212;
      4'd9:       base = 9'd243;
      4'd10:      base = 9'd273;
      4'd11:      base = 9'd304;
      default:    base = 9'd334;
    endcase
    if (leap && (month >= 4'd3)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Length of month m, counted from zero.
  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days
// Adds a day count to a Gregorian date, with year saturation at 9999.
// ----------------------------------------------------------------------------
// A request (start year, month, day and a day count) enters on the in_*
// valid/ready channel; the resulting date leaves on the out_* channel, one
// result per request, in order. Only the low ADD_BITS bits of the day count
// are used. A result past year 9999 reads 9999-12-31 with year_overflow set.
// The front takes a request in F_IDLE, forms the reciprocal product in
// F_MUL and the century residues in F_DIV, then forms the day of year in
// F_PUSH and hands the job to a two-entry queue, waiting there while the
// queue is full; it then takes the next request while the back is still
// busy. The back walks one year per cycle and then one month per cycle,
// crossing about 180 whole years for a 16-bit count and at most 11 months.
// It takes the next request only after handing the last to the output
// register, so this walk sets the throughput. An overflowing request ends
// its walk at the first year past 9999. Reset empties the queue and clears
// both state machines and the output valid. When the receiver stalls, the
// result stays in the output register, the back waits with the next
// finished date, and the queue and then the front fill before in_ready_o
// drops for good.
module date_add_days import dad_pkg::*; #(
  parameter int unsigned ADD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned OrdW       = ADD_BITS + 2;
  localparam int unsigned JobW       = $bits(job_hdr_t) + OrdW;
  localparam int unsigned QueueDepth = 2;

  logic            push, full, pop, empty;
  job_hdr_t        push_hdr, pop_hdr;
  logic [OrdW-1:0] push_ord, pop_ord;

  dad_front #(
    .AddBits (ADD_BITS),
    .OrdW    (OrdW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_hdr_o (push_hdr),
    .push_ord_o (push_ord),
    .full_i     (full)
  );

  dad_fifo #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_hdr, push_ord}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  ({pop_hdr, pop_ord}),
    .empty_o     (empty)
  );

  dad_back #(
    .OrdW (OrdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_hdr_i   (pop_hdr),
    .pop_ord_i   (pop_ord),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/dad_fifo.sv
// ----------------------------------------------------------------------------
// dad_fifo
// Small register queue between the front and back parts of the date adder.
// ----------------------------------------------------------------------------
module dad_fifo #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/dad_front.sv
// ----------------------------------------------------------------------------
// dad_front
// Accepts a request, finds the start year's century residues and forms the
// day of year plus the day count.
// ----------------------------------------------------------------------------
module dad_front import dad_pkg::*; #(
  parameter int unsigned AddBits = 16,
  parameter int unsigned OrdW    = AddBits + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            push_o,
  output job_hdr_t        push_hdr_o,
  output logic [OrdW-1:0] push_ord_o,
  input  logic            full_i
);

  front_state_e state_q, state_d;

  logic [13:0]        year_q;
  logic [3:0]         month_q;
  logic [4:0]         day_q;
  logic [AddBits-1:0] add_q;
  logic [26:0]        prod_q;
  logic [6:0]         mod100_q;
  logic [1:0]         cmod4_q;

  logic               accept;
  logic [7:0]         cent;
  logic [13:0]        rem;
  logic               leap;
  logic [OrdW-1:0]    ord;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MUL;
      F_MUL:   state_d = F_DIV;
      F_DIV:   state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE);
    push_o     = (state_q == F_PUSH);
  end

  // Century count from the registered reciprocal product, then the remainder.
  assign cent = prod_q[RECIP_SHIFT +: 8];
  assign rem  = year_q - (14'(cent) * 14'(CENTURY));

  assign leap = is_leap(year_q[1:0], mod100_q, cmod4_q);

  always_comb begin
    ord = OrdW'(days_before(month_q, leap)) + OrdW'(day_q) + OrdW'(add_q);
    // A zero day of year is read as January 1.
    if (ord == '0) begin
      ord = OrdW'(1);
    end
  end

  assign push_hdr_o = '{year: year_q, year_mod100: mod100_q, century_mod4: cmod4_q};
  assign push_ord_o = ord;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q  <= in_data_i.start_year;
      month_q <= in_data_i.start_month;
      day_q   <= in_data_i.start_day;
      add_q   <= AddBits'(in_data_i.days_to_add);
    end
    if (state_q == F_MUL) begin
      prod_q <= 27'(year_q) * 27'(RECIP_100);
    end
    if (state_q == F_DIV) begin
      mod100_q <= rem[6:0];
      cmod4_q  <= cent[1:0];
    end
  end

endmodule

// File: rtl/core/dad_back.sv
// ----------------------------------------------------------------------------
// dad_back
// Walks whole years and then months of one queued request, one step a cycle,
// and holds the finished date in the output register.
// ----------------------------------------------------------------------------
module dad_back import dad_pkg::*; #(
  parameter int unsigned OrdW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  job_hdr_t        pop_hdr_i,
  input  logic [OrdW-1:0] pop_ord_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o
);

  back_state_e state_q, state_d;

  logic [13:0]     year_q, year_d;
  logic [6:0]      mod100_q, mod100_d;
  logic [1:0]      cmod4_q, cmod4_d;
  logic [OrdW-1:0] ord_q, ord_d;
  logic [3:0]      mon_q, mon_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            leap;
  logic [8:0]      ylen;
  logic [4:0]      mlen;
  logic            past_max;
  logic            year_step;
  logic            month_step;
  logic            slot_free;

  assign leap       = is_leap(year_q[1:0], mod100_q, cmod4_q);
  assign ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen       = month_len(mon_q, leap);
  assign past_max   = (year_q > MAX_YEAR);
  assign year_step  = !past_max && (ord_q > OrdW'(ylen));
  assign month_step = (mon_q < LAST_MONTH) && (ord_q > OrdW'(mlen));
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_YEAR;
      B_YEAR:  if (past_max) state_d = B_OUT;
               else if (!year_step) state_d = B_MONTH;
      B_MONTH: if (!month_step) state_d = B_OUT;
      B_OUT:   if (slot_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == B_IDLE) && !empty_i;
    year_d      = year_q;
    mod100_d    = mod100_q;
    cmod4_d     = cmod4_q;
    ord_d       = ord_q;
    mon_d       = mon_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      B_IDLE: begin
        year_d   = pop_hdr_i.year;
        mod100_d = pop_hdr_i.year_mod100;
        cmod4_d  = pop_hdr_i.century_mod4;
        ord_d    = pop_ord_i;
        mon_d    = '0;
        ovf_d    = 1'b0;
      end
      B_YEAR: begin
        if (past_max) begin
          ovf_d = 1'b1;
        end else if (year_step) begin
          ord_d  = ord_q - OrdW'(ylen);
          year_d = year_q + 14'd1;
          if (mod100_q == CENTURY_LAST) begin
            mod100_d = '0;
            cmod4_d  = cmod4_q + 2'd1;
          end else begin
            mod100_d = mod100_q + 7'd1;
          end
        end
      end
      B_MONTH: begin
        if (month_step) begin
          ord_d = ord_q - OrdW'(mlen);
          mon_d = mon_q + 4'd1;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (ovf_q) begin
            out_d = '{result_year: MAX_YEAR, result_month: DEC_NUMBER,
                      result_day: DEC_LAST_DAY, year_overflow: 1'b1};
          end else begin
            out_d = '{result_year: year_q, result_month: mon_q + 4'd1,
                      result_day: ord_q[4:0], year_overflow: 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    mod100_q <= mod100_d;
    cmod4_q  <= cmod4_d;
    ord_q    <= ord_d;
    mon_q    <= mon_d;
    ovf_q    <= ovf_d;
    out_q    <= out_d;
  end

endmodule

// File: rtl/core/date_add_days_checker.sv
// ----------------------------------------------------------------------------
// date_add_days_checker
// Port-level assertions for the date adder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module date_add_days_checker import dad_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic ovf_date_ok;
  logic date_range_ok;

  assign ovf_date_ok   = (out_data_o.result_year == MAX_YEAR) &&
                         (out_data_o.result_month == DEC_NUMBER) &&
                         (out_data_o.result_day == DEC_LAST_DAY);
  assign date_range_ok = (out_data_o.result_year <= MAX_YEAR) &&
                         (out_data_o.result_month != 4'd0) &&
                         (out_data_o.result_month <= DEC_NUMBER) &&
                         (out_data_o.result_day != 5'd0);

  // A waiting request must stay put.
  `DAD_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))

  // A stalled result must stay put.
  `DAD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // The front drops in_ready_o after taking a request.
  `DAD_ASSERT(a_front_busy, in_valid_i && in_ready_o |=> !in_ready_o)

  // An overflowed result is always the last day of year 9999.
  `DAD_ASSERT(a_ovf_date, out_valid_o && out_data_o.year_overflow |-> ovf_date_ok)

  // A regular result names a month from 1 to 12, a nonzero day and a year no later than 9999.
  `DAD_ASSERT(a_date_range, out_valid_o && !out_data_o.year_overflow |-> date_range_ok)

endmodule

bind date_add_days date_add_days_checker u_checker (.*);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for date_add_days.
// ----------------------------------------------------------------------------
// Directed requests cover the calendar corners first. Random requests then run
// under three idle mixes on the two channels. A scoreboard predicts every
// resulting date and compares the results in order, field by field. Partway
// through, the output side stalls for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dad_pkg::*;

  localparam int unsigned PERIOD         = 20;
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned HOLD_AT        = 1200;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned DRAIN_CYCLES   = 250;

  class date_scoreboard;
    out_item_t   expected_dates[$];
    int unsigned checked;
    int unsigned errors;
    int unsigned overflows;

    function bit leap_year(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Month index counts from zero.
    function int unsigned days_in_month(int unsigned idx, bit leap);
      int unsigned len;
      case (idx)
        1:          len = leap ? 29 : 28;
        3, 5, 8, 10: len = 30;
        default:    len = 31;
      endcase
      return len;
    endfunction

    function int unsigned days_in_year(int unsigned yr);
      return leap_year(yr) ? int'(DAYS_LEAP) : int'(DAYS_COMMON);
    endfunction

    function out_item_t add_days(in_item_t req);
      int unsigned yr;
      int unsigned mon;
      int unsigned ord;
      int unsigned k;
      bit          leap;
      out_item_t   res;
      yr  = req.start_year;
      mon = req.start_month;
      if (mon > DEC_NUMBER) begin
        mon = DEC_NUMBER;
      end
      leap = leap_year(yr);
      ord  = 0;
      for (k = 1; k < mon; k++) begin
        ord += days_in_month(k - 1, leap);
      end
      ord += req.start_day;
      ord += req.days_to_add;
      if (ord == 0) begin
        ord = 1;
      end
      while (ord > days_in_year(yr)) begin
        ord -= days_in_year(yr);
        yr++;
      end
      if (yr > MAX_YEAR) begin
        res.result_year   = MAX_YEAR;
        res.result_month  = DEC_NUMBER;
        res.result_day    = DEC_LAST_DAY;
        res.year_overflow = 1'b1;
      end else begin
        leap = leap_year(yr);
        k = 0;
        while (k < LAST_MONTH && ord > days_in_month(k, leap)) begin
          ord -= days_in_month(k, leap);
          k++;
        end
        res.result_year   = yr[13:0];
        res.result_month  = 4'(k + 1);
        res.result_day    = ord[4:0];
        res.year_overflow = 1'b0;
      end
      return res;
    endfunction

    function void note_request(in_item_t req);
      expected_dates.push_back(add_days(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_dates.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp = expected_dates.pop_front();
      checked++;
      if (exp.year_overflow) begin
        overflows++;
      end
      if (got.result_year !== exp.result_year) begin
        $error("result_year: expected %0d, got %0d", exp.result_year, got.result_year);
        errors++;
      end
      if (got.result_month !== exp.result_month) begin
        $error("result_month: expected %0d, got %0d", exp.result_month, got.result_month);
        errors++;
      end
      if (got.result_day !== exp.result_day) begin
        $error("result_day: expected %0d, got %0d", exp.result_day, got.result_day);
        errors++;
      end
      if (got.year_overflow !== exp.year_overflow) begin
        $error("year_overflow: expected %0d, got %0d", exp.year_overflow,
               got.year_overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  date_scoreboard sb = new();
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    requests_sent = 0;
  int unsigned    quiet_cycles = 0;

  date_add_days #(.ADD_BITS(16)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever begin
      #(PERIOD / 2) clk_i = ~clk_i;
    end
  end

  function automatic in_item_t make_req(int unsigned yr, int unsigned mon,
                                        int unsigned dd, int unsigned add);
    in_item_t req;
    req.start_year  = 14'(yr);
    req.start_month = 4'(mon);
    req.start_day   = 5'(dd);
    req.days_to_add = 16'(add);
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
    sb.note_request(req);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic sender_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    sender_gap(1);
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic in_item_t random_request();
    int unsigned yr;
    int unsigned mon;
    int unsigned add;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick >= 85) begin
      // Raw noise: any field value, including months and days out of range.
      return make_req($urandom_range(0, 16383), $urandom_range(0, 15),
                      $urandom_range(0, 31), $urandom_range(0, 65535));
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      yr = $urandom_range(1, 9999);
    end else if (pick < 8) begin
      yr = $urandom_range(0, 99) * 100 + $urandom_range(0, 8) - 4;
    end else begin
      yr = $urandom_range(9800, 9999);
    end
    if (yr > 9999) begin
      yr = 9999;
    end
    mon = $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      add = $urandom_range(0, 62);
    end else if (pick < 7) begin
      add = $urandom_range(0, 1500);
    end else begin
      add = $urandom_range(0, 65535);
    end
    return make_req(yr, mon, $urandom_range(1, sb.days_in_month(mon - 1, sb.leap_year(yr))),
                    add);
  endfunction

  task automatic run_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      send_request(random_request());
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        sender_gap($urandom_range(1, 8));
      end
    end
    wait_drained();
  endtask

  // The receiver stalls once for a long stretch so that the block backs up.
  initial begin : result_receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && sb.checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t corner_reqs[$];
    corner_reqs = '{
      make_req(0, 1, 1, 0),
      make_req(0, 0, 0, 0),          // zero day of year gives January 1
      make_req(2023, 0, 15, 0),      // month zero counts as January
      make_req(2023, 15, 1, 0),      // month above twelve counts as December
      make_req(2024, 13, 31, 1),
      make_req(1900, 2, 28, 1),
      make_req(2000, 2, 28, 1),
      make_req(2004, 2, 28, 1),
      make_req(2100, 2, 28, 1),
      make_req(2023, 2, 31, 0),      // day past the end of the month carries over
      make_req(2023, 12, 31, 1),
      make_req(9999, 12, 31, 0),
      make_req(9999, 12, 31, 1),     // first day past the last year
      make_req(9999, 1, 1, 65535),
      make_req(16383, 1, 1, 0),      // start year above the last year
      make_req(10000, 6, 15, 0),
      make_req(0, 1, 1, 65535),
      make_req(1, 12, 31, 65535),
      make_req(9820, 1, 1, 65535),
      make_req(2400, 2, 29, 365),
      make_req(2023, 12, 31, 31),
      make_req(8191, 7, 16, 32768),
      make_req(1999, 12, 31, 366),
      make_req(2020, 3, 0, 0)
    };
    rx_idle_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (corner_reqs[i]) begin
      send_request(corner_reqs[i]);
    end
    wait_drained();

    run_random(500, 34, 51);
    run_random(500, 51, 34);
    run_random(600, 0, 0);

    sender_gap(DRAIN_CYCLES);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d requests: calendar corners, then random dates under three idle mixes",
             requests_sent);
    $display("and one long output stall; %0d results checked, %0d with year overflow.",
             sb.checked, sb.overflows);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dad_pkg.sv
rtl/core/dad_fifo.sv
rtl/core/dad_front.sv
rtl/core/dad_back.sv
rtl/core/date_add_days.sv
rtl/core/date_add_days_checker.sv
dv/tb.sv
